@@ design/hcrd_pkg.sv @@
package hcrd_pkg;

   localparam int MAX_REF_LEN = 12;
   localparam int CNT_W       = $clog2(MAX_REF_LEN + 1);
   localparam int IDX_W       = $clog2(MAX_REF_LEN);
   localparam int SEQ_W       = $clog2(MAX_REF_LEN + 4);
   localparam int JOB_DEPTH   = 2;
   localparam int NAME_COUNT  = 7;

   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;

   localparam logic [31:0] UTF8_ONE_MAX   = 32'h0000_007F;
   localparam logic [31:0] UTF8_TWO_MAX   = 32'h0000_07FF;
   localparam logic [31:0] UTF8_THREE_MAX = 32'h0000_FFFF;

   // nbsp, copy, quot, apos, amp, lt, gt (length counts the ';')
   localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd3, 3'd3};
   localparam logic [7:0] NAME_VALUE [NAME_COUNT] =
      '{8'hA0, 8'hA9, 8'h22, 8'h27, 8'h26, 8'h3C, 8'h3E};

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_AMP,
      MODE_HASH,
      MODE_DEC,
      MODE_HEX,
      MODE_NAME
   } mode_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       no_byte;
      logic       run_last;
      logic       text_done;
   } rsp_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
   } utf8_type;

   // One job: the held reference bytes to replay, then up to three tail bytes.
   typedef struct packed {
      logic [MAX_REF_LEN-1:0][7:0] held_bytes;
      logic [CNT_W-1:0]            held_count;
      logic [2:0][7:0]             tail_bytes;
      logic [1:0]                  tail_count;
      logic                        end_mark;
   } job_type;

   function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [2:0] pos);
      logic [47:0] row;
      logic [47:0] row_sh;
      case (idx)
         3'd0:    row = "nbsp; ";
         3'd1:    row = "copy; ";
         3'd2:    row = "quot; ";
         3'd3:    row = "apos; ";
         3'd4:    row = "amp;  ";
         3'd5:    row = "lt;   ";
         3'd6:    row = "gt;   ";
         default: row = '0;
      endcase
      row_sh = row << (8 * pos);
      return row_sh[47:40];
   endfunction

   function automatic utf8_type utf8_encode(input logic [31:0] value);
      utf8_type r;
      r = '0;
      if (value != '0 && value <= UTF8_ONE_MAX) begin
         r.bytes[0] = value[7:0];
         r.count    = 2'd1;
      end else if (value > UTF8_ONE_MAX && value <= UTF8_TWO_MAX) begin
         r.bytes[0] = {3'b110, value[10:6]};
         r.bytes[1] = {2'b10, value[5:0]};
         r.count    = 2'd2;
      end else if (value > UTF8_TWO_MAX && value <= UTF8_THREE_MAX) begin
         r.bytes[0] = {4'b1110, value[15:12]};
         r.bytes[1] = {2'b10, value[11:6]};
         r.bytes[2] = {2'b10, value[5:0]};
         r.count    = 2'd3;
      end
      return r;
   endfunction

endpackage

@@ design/hcrd_front.sv @@
module hcrd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  hcrd_pkg::req_type req_data,
   input  logic              job_full,
   output logic              job_push,
   output hcrd_pkg::job_type job_data
);

   hcrd_pkg::mode_type                 mode_ff, mode_in;
   logic [hcrd_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [31:0]                        code_ff, code_in;
   logic [hcrd_pkg::NAME_COUNT-1:0]    cand_ff, cand_in;
   logic [hcrd_pkg::MAX_REF_LEN-1:0][7:0] held_ff, held_in;

   logic                               accept;
   logic [7:0]                         b;
   logic                               eot;
   logic                               ovf;
   hcrd_pkg::mode_type                 eff_mode;
   logic [hcrd_pkg::CNT_W-1:0]         p_full;
   logic [2:0]                         p;
   logic [hcrd_pkg::NAME_COUNT-1:0]    mask, hit, done_hit;
   logic [7:0]                         name_val;
   logic                               is_dig, hex_ok;
   logic [3:0]                         hex_val;
   logic [31:0]                        dec_next, hex_next;
   logic                               act_append, act_fail, act_fin, idle_path;
   logic                               act_amp, act_lit;
   logic [31:0]                        fin_val;
   hcrd_pkg::mode_type                 app_mode;
   logic [31:0]                        app_code;
   logic [hcrd_pkg::NAME_COUNT-1:0]    app_cand;
   hcrd_pkg::utf8_type                 utf;

   assign accept   = req_push && !job_full;
   assign req_full = job_full;
   assign b        = req_data.text_byte;
   assign eot      = req_data.end_of_text;

   // name matching against the candidates still alive
   always_comb begin
      ovf      = (mode_ff != hcrd_pkg::MODE_IDLE) &&
                 (count_ff >= hcrd_pkg::CNT_W'(hcrd_pkg::MAX_REF_LEN));
      eff_mode = ovf ? hcrd_pkg::MODE_IDLE : mode_ff;
      p_full   = count_ff - 1'b1;
      p        = p_full[2:0];
      mask     = (eff_mode == hcrd_pkg::MODE_AMP) ? '1 : cand_ff;
      hit      = '0;
      done_hit = '0;
      for (int i = 0; i < hcrd_pkg::NAME_COUNT; i++) begin
         hit[i] = mask[i] &&
                  (p_full < hcrd_pkg::CNT_W'(hcrd_pkg::NAME_LEN[i])) &&
                  (hcrd_pkg::name_char(3'(i), p) == b);
         done_hit[i] = hit[i] &&
                       (p_full + 1'b1 == hcrd_pkg::CNT_W'(hcrd_pkg::NAME_LEN[i]));
      end
      name_val = '0;
      for (int i = hcrd_pkg::NAME_COUNT - 1; i >= 0; i--) begin
         if (done_hit[i]) begin
            name_val = hcrd_pkg::NAME_VALUE[i];
         end
      end
   end

   always_comb begin
      is_dig  = b inside {[hcrd_pkg::CHAR_0:hcrd_pkg::CHAR_9]};
      hex_ok  = 1'b1;
      hex_val = b[3:0];
      if (is_dig) begin
         hex_val = b[3:0];
      end else if (b inside {[hcrd_pkg::CHAR_UPPER_A:hcrd_pkg::CHAR_UPPER_F],
                             [hcrd_pkg::CHAR_LOWER_A:hcrd_pkg::CHAR_LOWER_F]}) begin
         hex_val = b[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
      dec_next = (code_ff << 3) + (code_ff << 1) + 32'(b[3:0]);
      hex_next = {code_ff[27:0], hex_val};
   end

   always_comb begin
      act_append = 1'b0;
      act_fail   = 1'b0;
      act_fin    = 1'b0;
      idle_path  = 1'b0;
      fin_val    = '0;
      app_mode   = mode_ff;
      app_code   = code_ff;
      app_cand   = cand_ff;
      case (eff_mode)
         hcrd_pkg::MODE_AMP, hcrd_pkg::MODE_NAME: begin
            if (eff_mode == hcrd_pkg::MODE_AMP && b == hcrd_pkg::CHAR_HASH) begin
               act_append = 1'b1;
               app_mode   = hcrd_pkg::MODE_HASH;
            end else if (|done_hit) begin
               act_fin = 1'b1;
               fin_val = 32'(name_val);
            end else if (hit == '0) begin
               act_fail = 1'b1;
            end else begin
               act_append = 1'b1;
               app_mode   = hcrd_pkg::MODE_NAME;
               app_cand   = hit;
            end
         end
         hcrd_pkg::MODE_HASH: begin
            if (b == hcrd_pkg::CHAR_LOWER_X) begin
               act_append = 1'b1;
               app_mode   = hcrd_pkg::MODE_HEX;
            end else if (is_dig) begin
               act_append = 1'b1;
               app_mode   = hcrd_pkg::MODE_DEC;
               app_code   = 32'(b[3:0]);
            end else if (b == hcrd_pkg::CHAR_SEMI) begin
               act_fin = 1'b1;
            end else begin
               act_fail = 1'b1;
            end
         end
         hcrd_pkg::MODE_DEC: begin
            if (is_dig) begin
               act_append = 1'b1;
               app_code   = dec_next;
            end else if (b == hcrd_pkg::CHAR_SEMI) begin
               act_fin = 1'b1;
               fin_val = code_ff;
            end else begin
               act_fail = 1'b1;
            end
         end
         hcrd_pkg::MODE_HEX: begin
            if (hex_ok) begin
               act_append = 1'b1;
               app_code   = hex_next;
            end else if (b == hcrd_pkg::CHAR_SEMI) begin
               act_fin = 1'b1;
               fin_val = code_ff;
            end else begin
               act_fail = 1'b1;
            end
         end
         default: idle_path = 1'b1;
      endcase
   end

   assign act_amp = (idle_path || act_fail) && (b == hcrd_pkg::CHAR_AMP);
   assign act_lit = (idle_path || act_fail) && (b != hcrd_pkg::CHAR_AMP);
   assign utf     = hcrd_pkg::utf8_encode(fin_val);

   // replayed bytes always come from the buffer as it stood before this beat
   always_comb begin
      job_data            = '0;
      job_data.held_bytes = held_ff;
      job_data.end_mark   = eot;
      if (ovf || act_fail || (eot && act_append)) begin
         job_data.held_count = count_ff;
      end
      if (act_fin) begin
         job_data.tail_bytes = utf.bytes;
         job_data.tail_count = utf.count;
      end else if (act_lit || (eot && (act_append || act_amp))) begin
         job_data.tail_bytes[0] = b;
         job_data.tail_count    = 2'd1;
      end
      job_push = accept &&
                 (job_data.held_count != '0 || job_data.tail_count != '0 || eot);
   end

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      code_in  = code_ff;
      cand_in  = cand_ff;
      held_in  = held_ff;
      if (accept) begin
         if (act_amp) begin
            held_in[0] = b;
         end else if (act_append) begin
            held_in[count_ff[hcrd_pkg::IDX_W-1:0]] = b;
         end
         if (eot || !(act_append || act_amp)) begin
            mode_in  = hcrd_pkg::MODE_IDLE;
            count_in = '0;
            code_in  = '0;
            cand_in  = '0;
         end else if (act_amp) begin
            mode_in  = hcrd_pkg::MODE_AMP;
            count_in = hcrd_pkg::CNT_W'(1);
            code_in  = '0;
            cand_in  = '0;
         end else begin
            mode_in  = app_mode;
            count_in = count_ff + 1'b1;
            code_in  = app_code;
            cand_in  = app_cand;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= hcrd_pkg::MODE_IDLE;
         count_ff <= '0;
         code_ff  <= '0;
         cand_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         code_ff  <= code_in;
         cand_ff  <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

@@ design/hcrd_job_fifo.sv @@
module hcrd_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hcrd_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output hcrd_pkg::job_type head,
   output logic              empty
);

   localparam int PTR_W = $clog2(hcrd_pkg::JOB_DEPTH);
   localparam int FILL_W = $clog2(hcrd_pkg::JOB_DEPTH + 1);

   hcrd_pkg::job_type  entries_ff [hcrd_pkg::JOB_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full    = (fill_ff == FILL_W'(hcrd_pkg::JOB_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(hcrd_pkg::JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(hcrd_pkg::JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/hcrd_back.sv @@
module hcrd_back (
   input  logic              clock,
   input  logic              reset,
   input  hcrd_pkg::job_type job,
   input  logic              job_empty,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output hcrd_pkg::rsp_type rsp_data
);

   logic [hcrd_pkg::SEQ_W-1:0] idx_ff, idx_in;
   logic                       valid_ff, valid_in;
   hcrd_pkg::rsp_type          out_ff, out_in;

   logic [hcrd_pkg::SEQ_W-1:0] held_n, total, last_idx, tail_pos;
   logic                       empty_job, is_last, advance;
   logic [7:0]                 byte_sel;

   always_comb begin
      held_n    = hcrd_pkg::SEQ_W'(job.held_count);
      total     = held_n + hcrd_pkg::SEQ_W'(job.tail_count);
      empty_job = (total == '0);
      last_idx  = empty_job ? '0 : total - 1'b1;
      is_last   = (idx_ff == last_idx);
      advance   = !job_empty && (!valid_ff || rsp_pop);
      job_pop   = advance && is_last;
      tail_pos  = idx_ff - held_n;
      byte_sel  = '0;
      if (idx_ff < held_n) begin
         byte_sel = job.held_bytes[idx_ff[hcrd_pkg::IDX_W-1:0]];
      end else begin
         case (tail_pos[1:0])
            2'd0:    byte_sel = job.tail_bytes[0];
            2'd1:    byte_sel = job.tail_bytes[1];
            2'd2:    byte_sel = job.tail_bytes[2];
            default: byte_sel = '0;
         endcase
      end
      if (empty_job) begin
         byte_sel = '0;
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (advance) begin
         idx_in           = is_last ? '0 : idx_ff + 1'b1;
         valid_in         = 1'b1;
         out_in.out_byte  = byte_sel;
         out_in.no_byte   = empty_job;
         out_in.run_last  = is_last;
         out_in.text_done = is_last && job.end_mark;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ design/html_char_reference_decoder.sv @@
// Channel   Ports                                  Beat taken when
// input     req_push, req_full, req_data           req_push && !req_full
// result    rsp_empty, rsp_pop, rsp_data           rsp_pop && !rsp_empty
//
// The front end takes one byte a cycle while req_full is low and updates the reference
// scanner in that cycle. Each byte that yields output becomes a job in a two-entry
// queue; the back end emits one result a cycle unless a held result waits for rsp_pop.
// A flush of a long or failed reference (up to MAX_REF_LEN + 1 results) stalls input
// once the queue fills. Synchronous reset clears control; no clearing pass.
module html_char_reference_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  hcrd_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output hcrd_pkg::rsp_type rsp_data
);

   hcrd_pkg::job_type push_job, head_job;
   logic              job_push, job_full, job_pop, job_empty;

   hcrd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .job_full (job_full),
      .job_push (job_push),
      .job_data (push_job)
   );

   hcrd_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .head      (head_job),
      .empty     (job_empty)
   );

   hcrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/hcrd_checker.sv @@
module hcrd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input hcrd_pkg::rsp_type rsp_data
);

   // an empty end-of-text beat carries nothing but the end mark
   a_no_byte_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.no_byte) |->
         (rsp_data.run_last && rsp_data.text_done && rsp_data.out_byte == 8'h00))
      else $error("no_byte beat malformed");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.text_done) |-> rsp_data.run_last)
      else $error("text_done without run_last");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result pending after reset");

   a_reset_not_full: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("input blocked after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind html_char_reference_decoder hcrd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
